// ----- rtl/erm_pkg.sv -----
// Package for the Euler rotation matrix block: widths, CORDIC constants and axis codes.
// Used by erm_sincos, erm_matmul and euler_rotation_matrix; depends on nothing.
`default_nettype none
package erm_pkg;
    localparam int ANGLE_WIDTH  = 16;
    localparam int ENTRY_WIDTH  = 16;
    localparam int CORDIC_STEPS = 31;
    localparam int IW = 34;
    localparam int STAGES_PER_REG = 2;

    localparam logic signed [IW-1:0] PI30  = 34'sd3373259426;
    localparam logic signed [IW-1:0] HPI30 = 34'sd1686629713;
    localparam logic signed [IW-1:0] GAIN  = 34'sd652032874;
    localparam logic signed [IW-1:0] ONE30 = 34'sd1073741824;

    typedef logic signed [IW-1:0] t_wide;
    typedef logic signed [31:0] t_q30;
    typedef logic [1:0] t_axis;

    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    localparam logic [1:0] MODE_XYZ = 2'd0;
    localparam logic [1:0] MODE_ZYX = 2'd1;
    localparam logic [1:0] MODE_ZXZ = 2'd2;

    function automatic t_wide atan_tab(input logic [4:0] i);
        case (i)
            5'd0: atan_tab = 34'sd843314856;
            5'd1: atan_tab = 34'sd497837829;
            5'd2: atan_tab = 34'sd263043836;
            5'd3: atan_tab = 34'sd133525158;
            5'd4: atan_tab = 34'sd67021686;
            5'd5: atan_tab = 34'sd33543515;
            5'd6: atan_tab = 34'sd16775850;
            5'd7: atan_tab = 34'sd8388437;
            5'd8: atan_tab = 34'sd4194282;
            5'd9: atan_tab = 34'sd2097149;
            5'd10: atan_tab = 34'sd1048575;
            5'd11: atan_tab = 34'sd524287;
            5'd12: atan_tab = 34'sd262143;
            5'd13: atan_tab = 34'sd131071;
            5'd14: atan_tab = 34'sd65535;
            5'd15: atan_tab = 34'sd32767;
            5'd16: atan_tab = 34'sd16383;
            5'd17: atan_tab = 34'sd8191;
            5'd18: atan_tab = 34'sd4095;
            5'd19: atan_tab = 34'sd2047;
            5'd20: atan_tab = 34'sd1023;
            5'd21: atan_tab = 34'sd511;
            5'd22: atan_tab = 34'sd255;
            5'd23: atan_tab = 34'sd127;
            5'd24: atan_tab = 34'sd63;
            5'd25: atan_tab = 34'sd31;
            5'd26: atan_tab = 34'sd15;
            5'd27: atan_tab = 34'sd8;
            5'd28: atan_tab = 34'sd4;
            5'd29: atan_tab = 34'sd2;
            5'd30: atan_tab = 34'sd1;
            default: atan_tab = '0;
        endcase
    endfunction

    function automatic t_axis seq_axis(input logic [1:0] mode, input logic [1:0] pos);
        t_axis a;
        a = AXIS_Z;
        case (mode)
            MODE_XYZ: a = (pos == 2'd0) ? AXIS_X : ((pos == 2'd1) ? AXIS_Y : AXIS_Z);
            MODE_ZYX: a = (pos == 2'd0) ? AXIS_Z : ((pos == 2'd1) ? AXIS_Y : AXIS_X);
            MODE_ZXZ: a = (pos == 2'd1) ? AXIS_X : AXIS_Z;
            default:  a = (pos == 2'd1) ? AXIS_Y : AXIS_Z;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/erm_sincos.sv -----
// Pipelined CORDIC sine and cosine of one Q3.13 angle on a Q.30 grid.
// Two rotation steps per register stage, with range reduction first; uses erm_pkg.
`default_nettype none
module erm_sincos import erm_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [31:0]                 o_sin,
    output logic signed [31:0]                 o_cos
);
    localparam int NREG = (CORDIC_STEPS + STAGES_PER_REG - 1) / STAGES_PER_REG;

    t_wide z0;
    t_wide z1;
    t_wide z2;
    logic  flip0;
    t_wide r_x [NREG+1];
    t_wide r_y [NREG+1];
    t_wide r_z [NREG];
    logic  r_flip [NREG+1];
    t_wide r_c;
    t_wide r_s;

    always_comb begin
        z0 = t_wide'(i_angle) <<< (33 - ANGLE_WIDTH);
        z1 = z0;
        if (z0 >= PI30) begin
            z1 = z0 - (PI30 <<< 1);
        end else if (z0 < -PI30) begin
            z1 = z0 + (PI30 <<< 1);
        end
        z2 = z1;
        flip0 = 1'b0;
        if (z1 > HPI30) begin
            z2 = z1 - PI30;
            flip0 = 1'b1;
        end else if (z1 < -HPI30) begin
            z2 = z1 + PI30;
            flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN;
            r_y[0] <= '0;
            r_z[0] <= z2;
            r_flip[0] <= flip0;
        end
    end

    for (genvar g = 0; g < NREG; g++) begin : g_stage
        t_wide n_x;
        t_wide n_y;
        t_wide n_z;
        always_comb begin
            t_wide dx;
            t_wide dy;
            n_x = r_x[g];
            n_y = r_y[g];
            n_z = r_z[g];
            for (int k = 0; k < STAGES_PER_REG; k++) begin
                if (g * STAGES_PER_REG + k < CORDIC_STEPS) begin
                    dx = n_y >>> (g * STAGES_PER_REG + k);
                    dy = n_x >>> (g * STAGES_PER_REG + k);
                    if (!n_z[IW-1]) begin
                        n_x = n_x - dx;
                        n_y = n_y + dy;
                        n_z = n_z - atan_tab(5'(g * STAGES_PER_REG + k));
                    end else begin
                        n_x = n_x + dx;
                        n_y = n_y - dy;
                        n_z = n_z + atan_tab(5'(g * STAGES_PER_REG + k));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1] <= n_x;
                r_y[g+1] <= n_y;
                r_flip[g+1] <= r_flip[g];
            end
        end
        if (g < NREG - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[g+1] <= n_z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= r_flip[NREG] ? -r_x[NREG] : r_x[NREG];
            r_s <= r_flip[NREG] ? -r_y[NREG] : r_y[NREG];
        end
    end

    always_comb begin
        o_cos = (r_c > ONE30) ? 32'(ONE30) : ((r_c < -ONE30) ? -32'(ONE30) : 32'(r_c));
        o_sin = (r_s > ONE30) ? 32'(ONE30) : ((r_s < -ONE30) ? -32'(ONE30) : 32'(r_s));
    end
endmodule
`default_nettype wire

// ----- rtl/erm_matmul.sv -----
// Pipelined 3x3 product of two Q.30 matrices, rounded to Q.30.
// Products registered, then summed and rounded; uses erm_pkg.
`default_nettype none
module erm_matmul import erm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_a [9],
    input  wire logic signed [31:0] i_b [9],
    output logic signed [31:0]      o_p [9]
);
    logic signed [63:0] r_prod [27];
    logic signed [31:0] r_p [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[(i*3+j)*3+k] <= 64'(i_a[i*3+k]) * 64'(i_b[k*3+j]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < 9; e++) begin
                r_p[e] <= 32'((r_prod[e*3] + r_prod[e*3+1] + r_prod[e*3+2]
                          + 64'sd536870912) >>> 30);
            end
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- rtl/euler_rotation_matrix.sv -----
// Top level of the Euler rotation matrix block: three CORDIC units, two matrix products.
// Depends on erm_pkg, erm_sincos and erm_matmul.
//
// Usage: a request on the s_axis channel carries mode (tuser) and three Q3.13 angles
// (tdata). The m_axis channel returns the nine Q1.14 entries of the rotation matrix
// in row-major order. The datapath is one pipeline that advances only when its last
// stage is empty or taken, so a new request is accepted every cycle while the
// receiver keeps up. From acceptance to the result the pipeline holds one range
// reduction stage, sixteen CORDIC stages of two rotations each (the last holds one),
// one sign and clamp stage, two stages for each matrix product and one output
// rounding stage.
// Throughput is one item per cycle. When the receiver stalls, the whole pipeline
// holds and s_axis_tready falls; nothing is lost or repeated. Reset empties the
// pipeline by clearing the valid bits; payload registers are not reset.
`default_nettype none
module euler_rotation_matrix import erm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // angle_first, angle_second, angle_third from bit 0 up
    input  wire logic [3*ANGLE_WIDTH-1:0]   s_axis_tdata,
    // mode
    input  wire logic [1:0]                 s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // m_row0_col0 .. m_row2_col2 from bit 0 up
    output logic [9*ENTRY_WIDTH-1:0]        m_axis_tdata
);
    localparam int NREG = (CORDIC_STEPS + STAGES_PER_REG - 1) / STAGES_PER_REG;
    localparam int LAT_SC = NREG + 2;
    localparam int LAT = LAT_SC + 5;
    localparam int SH = 32 - ENTRY_WIDTH;
    localparam logic signed [31:0] LIM = 32'sd1 <<< (ENTRY_WIDTH - 2);

    logic            en;
    logic [LAT-1:0]  r_vld;
    logic [1:0]      r_mode [LAT_SC];
    logic signed [31:0] sn [3];
    logic signed [31:0] cs [3];
    logic signed [31:0] m1 [9];
    logic signed [31:0] m2 [9];
    logic signed [31:0] m3 [9];
    logic signed [31:0] r_m3a [9];
    logic signed [31:0] r_m3b [9];
    logic signed [31:0] p [9];
    logic signed [31:0] rr [9];
    logic [9*ENTRY_WIDTH-1:0] r_out;

    assign en = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mode[0] <= s_axis_tuser;
            for (int k = 1; k < LAT_SC; k++) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_sc
        erm_sincos u_sc (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH]),
            .o_sin   (sn[a]),
            .o_cos   (cs[a])
        );
    end

    function automatic void build(input t_axis ax, input logic signed [31:0] s,
                                  input logic signed [31:0] c,
                                  output logic signed [31:0] m [9]);
        logic [1:0] pp;
        logic [1:0] qq;
        pp = (ax == AXIS_Z) ? 2'd0 : ax + 2'd1;
        qq = (pp == AXIS_Z) ? 2'd0 : pp + 2'd1;
        for (int e = 0; e < 9; e++) begin
            m[e] = '0;
        end
        m[ax*3+ax] = 32'(ONE30);
        m[pp*3+pp] = c;
        m[pp*3+qq] = -s;
        m[qq*3+pp] = s;
        m[qq*3+qq] = c;
    endfunction

    always_comb begin
        build(seq_axis(r_mode[LAT_SC-1], 2'd0), sn[0], cs[0], m1);
        build(seq_axis(r_mode[LAT_SC-1], 2'd1), sn[1], cs[1], m2);
        build(seq_axis(r_mode[LAT_SC-1], 2'd2), sn[2], cs[2], m3);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3a <= m3;
            r_m3b <= r_m3a;
        end
    end

    erm_matmul u_mm1 (.i_clk(i_clk), .i_en(en), .i_a(m1), .i_b(m2), .o_p(p));
    erm_matmul u_mm2 (.i_clk(i_clk), .i_en(en), .i_a(p), .i_b(r_m3b), .o_p(rr));

    always_ff @(posedge i_clk) begin
        logic signed [32:0] v;
        if (en) begin
            for (int e = 0; e < 9; e++) begin
                if (SH == 0) begin
                    v = 33'(rr[e]);
                end else begin
                    v = (33'(rr[e]) + (33'sd1 <<< (SH - 1))) >>> SH;
                end
                if (v > 33'(LIM)) begin
                    v = 33'(LIM);
                end else if (v < -33'(LIM)) begin
                    v = -33'(LIM);
                end
                r_out[e*ENTRY_WIDTH +: ENTRY_WIDTH] <= v[ENTRY_WIDTH-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[LAT-2] |=> m_axis_tvalid)
        else $error("item lost in pipeline");
endmodule
`default_nettype wire

// ----- tb/tb_euler_rotation_matrix_chk.sv -----
// Checker for the Euler rotation matrix block: watches both stream channels, predicts
// each rotation matrix from the accepted angles and compares it entry by entry.
// Depends on erm_pkg.
`timescale 1ns / 1ps
module tb_euler_rotation_matrix_chk import erm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    input  wire logic                     s_axis_tready,
    input  wire logic [3*ANGLE_WIDTH-1:0] s_axis_tdata,
    input  wire logic [1:0]               s_axis_tuser,
    input  wire logic                     m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic [9*ENTRY_WIDTH-1:0] m_axis_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    typedef longint t_mat [3][3];

    logic [9*ENTRY_WIDTH-1:0] matrix_q[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sincos(longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN;
        y = 0;
        flip = 0;
        z = ang * (longint'(1) << (33 - ANGLE_WIDTH));
        if (z >= PI30) z -= 2 * longint'(PI30);
        if (z < -longint'(PI30)) z += 2 * longint'(PI30);
        if (z > HPI30) begin
            z -= PI30;
            flip = 1;
        end else if (z < -longint'(HPI30)) begin
            z += PI30;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab(5'(i));
            end else begin
                x += dx; y -= dy; z += atan_tab(5'(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = (x > ONE30) ? longint'(ONE30) : (x < -longint'(ONE30)) ? -longint'(ONE30) : x;
        s = (y > ONE30) ? longint'(ONE30) : (y < -longint'(ONE30)) ? -longint'(ONE30) : y;
    endfunction

    function automatic t_mat axis_rot(int ax, longint ang);
        t_mat m;
        longint s, c;
        int p, q;
        cordic_sincos(ang, s, c);
        foreach (m[i, j]) m[i][j] = 0;
        p = (ax + 1) % 3;
        q = (ax + 2) % 3;
        m[ax][ax] = ONE30;
        m[p][p] = c; m[p][q] = -s;
        m[q][p] = s; m[q][q] = c;
        return m;
    endfunction

    function automatic t_mat mul_q30(t_mat a, t_mat b);
        t_mat o;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
                o[i][j] = floor_sh(acc + (longint'(1) << 29), 30);
            end
        return o;
    endfunction

    function automatic logic [9*ENTRY_WIDTH-1:0] rotation_matrix(logic [1:0] mode,
            logic [3*ANGLE_WIDTH-1:0] angles);
        int axes [3];
        t_mat r;
        longint v, lim;
        logic [9*ENTRY_WIDTH-1:0] res;
        lim = longint'(1) << (ENTRY_WIDTH - 2);
        case (mode)
            MODE_XYZ: axes = '{0, 1, 2};
            MODE_ZYX: axes = '{2, 1, 0};
            MODE_ZXZ: axes = '{2, 0, 2};
            default:  axes = '{2, 1, 2};
        endcase
        r = axis_rot(axes[0], longint'($signed(angles[ANGLE_WIDTH-1:0])));
        r = mul_q30(r, axis_rot(axes[1],
                longint'($signed(angles[2*ANGLE_WIDTH-1:ANGLE_WIDTH]))));
        r = mul_q30(r, axis_rot(axes[2],
                longint'($signed(angles[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]))));
        for (int j = 0; j < 9; j++) begin
            v = floor_sh(r[j/3][j%3] + (longint'(1) << (31 - ENTRY_WIDTH)), 32 - ENTRY_WIDTH);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            res[j*ENTRY_WIDTH +: ENTRY_WIDTH] = v[ENTRY_WIDTH-1:0];
        end
        return res;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = matrix_q.size();

    always @(posedge i_clk) begin
        logic [9*ENTRY_WIDTH-1:0] want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            matrix_q = {matrix_q, rotation_matrix(s_axis_tuser, s_axis_tdata)};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (matrix_q.size() == 0) begin
                $error("result with no request waiting: %h", m_axis_tdata);
                o_fail_count = o_fail_count + 1;
            end else begin
                want = matrix_q.pop_front();
                for (int j = 0; j < 9; j++)
                    if (want[j*ENTRY_WIDTH +: ENTRY_WIDTH]
                            !== m_axis_tdata[j*ENTRY_WIDTH +: ENTRY_WIDTH]) begin
                        $error("m_row%0d_col%0d: expected %0d, got %0d", j / 3, j % 3,
                            $signed(want[j*ENTRY_WIDTH +: ENTRY_WIDTH]),
                            $signed(m_axis_tdata[j*ENTRY_WIDTH +: ENTRY_WIDTH]));
                        o_fail_count = o_fail_count + 1;
                    end
            end
        end
    end
endmodule

// ----- tb/tb_euler_rotation_matrix.sv -----
// Testbench top for the Euler rotation matrix block: drives angle requests in bursts,
// stalls the result side, and gives the verdict from the checker's failure and pending counts.
// Depends on erm_pkg, euler_rotation_matrix and tb_euler_rotation_matrix_chk.
`timescale 1ns / 1ps
module tb_euler_rotation_matrix;
    import erm_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [3*ANGLE_WIDTH-1:0] s_axis_tdata = '0;
    logic [1:0]               s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [9*ENTRY_WIDTH-1:0] m_axis_tdata;
    int                       fail_count;
    int                       pending;
    bit                       stall_free = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    euler_rotation_matrix dut (.*);

    tb_euler_rotation_matrix_chk chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls in phases: long free-running stretches alternate with random patterns.
    always @(posedge i_clk) begin
        if (stall_free) m_axis_tready <= 1'b1;
        else m_axis_tready <= (($time / 400) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(0, 8) * 16'd6434 - 16'd25736;
            3: return $urandom_range(0, 31) - 16;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_angles(logic [1:0] mode, logic [3*ANGLE_WIDTH-1:0] angles);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= angles;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    initial begin
        logic [ANGLE_WIDTH-1:0] edge_vals [6];
        int burst, sent, wait_cycles;
        edge_vals = '{16'h0000, 16'h7fff, 16'h8000, 16'd25736, 16'd12868, 16'hcdbc};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 4; m++)
            for (int k = 0; k < 6; k++)
                send_angles(m[1:0], {edge_vals[(k+2)%6], edge_vals[(k+1)%6], edge_vals[k]});
        sent = 0;
        while (sent < 1550) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_angles($urandom_range(0, 3), {pick_angle(), pick_angle(), pick_angle()});
                sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_sender();
            if (sent > 800) stall_free <= ($urandom_range(0, 1) == 1);
        end
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/erm_pkg.sv
rtl/erm_sincos.sv
rtl/erm_matmul.sv
rtl/euler_rotation_matrix.sv
tb/tb_euler_rotation_matrix_chk.sv
tb/tb_euler_rotation_matrix.sv
